>>> rtl/srcast_pkg.sv
// ----------------------------------------------------------------------------
// srcast_pkg: shared types and codes for the segment-set raycaster
// Sequencer states, axis codes and divider status.
// ----------------------------------------------------------------------------
package srcast_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHECK,
		ST_DIV,
		ST_FOLD
	} state_t;

	typedef logic [1:0] axis_t;

	localparam axis_t AXIS_RAY   = 2'd0;
	localparam axis_t AXIS_RAY_N = 2'd1;
	localparam axis_t AXIS_SEG   = 2'd2;
	localparam axis_t AXIS_SEG_N = 2'd3;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> rtl/srcast_in_if.sv
// ----------------------------------------------------------------------------
// srcast_in_if: input item channel
// Ray, one segment and the last flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface srcast_in_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] ray_from_x;
	logic signed [COORD_BITS-1:0] ray_from_y;
	logic signed [COORD_BITS-1:0] ray_to_x;
	logic signed [COORD_BITS-1:0] ray_to_y;
	logic signed [COORD_BITS-1:0] seg_a_x;
	logic signed [COORD_BITS-1:0] seg_a_y;
	logic signed [COORD_BITS-1:0] seg_b_x;
	logic signed [COORD_BITS-1:0] seg_b_y;
	logic                         last_segment;

	modport source (
		output valid, ray_from_x, ray_from_y, ray_to_x, ray_to_y,
		output seg_a_x, seg_a_y, seg_b_x, seg_b_y, last_segment,
		input  ready
	);
	modport sink (
		input  valid, ray_from_x, ray_from_y, ray_to_x, ray_to_y,
		input  seg_a_x, seg_a_y, seg_b_x, seg_b_y, last_segment,
		output ready
	);
endinterface

>>> rtl/srcast_out_if.sv
// ----------------------------------------------------------------------------
// srcast_out_if: result item channel
// Hit ratio in Q1.FRAC_BITS, valid/ready handshake.
// ----------------------------------------------------------------------------
interface srcast_out_if #(
	parameter int FRAC_BITS = 16
);
	logic               valid;
	logic               ready;
	logic [FRAC_BITS:0] hit_ratio;

	modport source (output valid, hit_ratio, input ready);
	modport sink (input valid, hit_ratio, output ready);
endinterface

>>> rtl/srcast_mul.sv
// ----------------------------------------------------------------------------
// srcast_mul: shared signed multiplier
// One axis component times one coordinate per cycle, product registered.
// ----------------------------------------------------------------------------
module srcast_mul #(
	parameter int AW = 17,
	parameter int BW = 16
) (
	input  logic                    clk,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p_s1
);
	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end
endmodule

>>> rtl/srcast_div.sv
// ----------------------------------------------------------------------------
// srcast_div: restoring divider for entry fractions
// One quotient bit per cycle; needs num < den.
// ----------------------------------------------------------------------------
module srcast_div #(
	parameter int NW = 35,
	parameter int QW = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [NW-1:0]               num,
	input  logic [NW-1:0]               den,
	output srcast_pkg::div_stat_t       stat,
	output logic [QW-1:0]               q
);
	localparam int CW = $clog2(QW + 1);

	logic [NW:0]   r_q;
	logic [NW-1:0] d_q;
	logic [QW-1:0] q_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [NW:0]   r_sh;
	logic          ge;

	assign r_sh = {r_q[NW-1:0], 1'b0};
	assign ge   = r_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= {1'b0, num};
			d_q <= den;
			q_q <= '0;
		end else if (busy_q) begin
			r_q <= ge ? (r_sh - {1'b0, d_q}) : r_sh;
			q_q <= {q_q[QW-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign q         = q_q;
endmodule

>>> rtl/segment_set_raycast_top.sv
// ----------------------------------------------------------------------------
// segment_set_raycast_top: first entry of a ray into a set of wall segments
// Separating-axis test per segment, running minimum per query.
// ----------------------------------------------------------------------------
// Usage:
//  in_ch carries one item per segment: the query ray (same for the whole
//  query), one segment and last_segment. out_ch gives one item, hit_ratio
//  in Q1.FRAC_BITS (1 << FRAC_BITS = no hit), for each item marked last.
//  One item at a time: in_ch.ready is high only while the sequencer idles.
//  Per axis (four of them, fewer once one separates) eight products go
//  through the single shared multiplier, a check step follows, and when
//  the fraction needs it the restoring divider runs and then hands back
//  the quotient. The divider sets an item's worst case.
//  Reset clears the sequencer and sets the running minimum to one.
//  The result sits in an output register; while it is stalled, every
//  following item waits in the fold step until the register frees.
// ----------------------------------------------------------------------------
module segment_set_raycast_top #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	srcast_in_if.sink   in_ch,
	srcast_out_if.source out_ch
);
	localparam int AW = COORD_BITS + 1;        // axis component
	localparam int PW = AW + COORD_BITS;       // one product
	localparam int DW = 2 * COORD_BITS + 4;    // dot, negated, differences
	localparam int FW = FRAC_BITS + 1;         // fraction
	localparam logic [FW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	srcast_pkg::state_t state_q, state_d;

	// captured item
	logic signed [COORD_BITS-1:0] p_q [8];
	logic                         last_q;

	logic [3:0]              m_q;       // product issue counter
	srcast_pkg::axis_t       k_q;       // current axis
	logic                    mul_v_s1;
	logic [2:0]              mul_tag_s1;
	logic signed [DW-1:0]    s_q [4];   // dots: from, to, a, b
	logic [FW-1:0]           best_q;
	logic                    sep_q;
	logic [FW-1:0]           min_q;
	logic                    out_v_q;
	logic [FW-1:0]           out_d_q;

	// axes from the captured points
	logic signed [AW-1:0] rdx, rdy, sdx, sdy, ax, ay, opa;
	logic signed [PW-1:0] prod_s1;
	logic signed [DW-1:0] prod_x;

	assign rdx = AW'(p_q[2]) - AW'(p_q[0]);
	assign rdy = AW'(p_q[3]) - AW'(p_q[1]);
	assign sdx = AW'(p_q[6]) - AW'(p_q[4]);
	assign sdy = AW'(p_q[7]) - AW'(p_q[5]);

	always_comb begin
		case (k_q)
			srcast_pkg::AXIS_RAY: begin
				ax = rdx;
				ay = rdy;
			end
			srcast_pkg::AXIS_RAY_N: begin
				ax = -rdy;
				ay = rdx;
			end
			srcast_pkg::AXIS_SEG: begin
				ax = sdx;
				ay = sdy;
			end
			default: begin
				ax = -sdy;
				ay = sdx;
			end
		endcase
	end

	// even tag: x term, odd tag: y term of the dot with point tag/2
	assign opa = m_q[0] ? ay : ax;

	srcast_mul #(.AW(AW), .BW(COORD_BITS)) u_mul (
		.clk  (clk),
		.a    (opa),
		.b    (p_q[m_q[2:0]]),
		.p_s1 (prod_s1)
	);

	assign prod_x = DW'(prod_s1);

	// per-axis check: orient so the ray runs low to high
	logic                 flip;
	logic signed [DW-1:0] sf, st, sa, sb, lo, hi, num, den;
	logic                 sep;

	always_comb begin
		flip = s_q[0] > s_q[1];
		sf   = flip ? -s_q[0] : s_q[0];
		st   = flip ? -s_q[1] : s_q[1];
		sa   = flip ? -s_q[2] : s_q[2];
		sb   = flip ? -s_q[3] : s_q[3];
		lo   = (sa < sb) ? sa : sb;
		hi   = (sa < sb) ? sb : sa;
		sep  = (sf > hi) || (st < lo);
		num  = lo - sf;
		den  = st - sf;
	end

	logic                  div_start;
	srcast_pkg::div_stat_t div_stat;
	logic [FRAC_BITS-1:0]  div_q;

	srcast_div #(.NW(DW - 1), .QW(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num[DW-2:0]),
		.den    (den[DW-2:0]),
		.stat   (div_stat),
		.q      (div_q)
	);

	// sequencer
	logic          adv;       // axis fraction ready this cycle
	logic [FW-1:0] frac;
	logic          fold_go;
	logic [FW-1:0] ratio, new_min;

	assign ratio   = sep_q ? ONE : best_q;
	assign new_min = (ratio < min_q) ? ratio : min_q;

	always_comb begin
		state_d   = state_q;
		adv       = 1'b0;
		frac      = '0;
		div_start = 1'b0;
		fold_go   = 1'b0;
		in_ch.ready = 1'b0;
		case (state_q)
			srcast_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid)
					state_d = srcast_pkg::ST_MUL;
			end
			srcast_pkg::ST_MUL: begin
				if (m_q == 4'd8)
					state_d = srcast_pkg::ST_CHECK;
			end
			srcast_pkg::ST_CHECK: begin
				// negative or zero numerator, or zero divisor: fraction zero
				if (sep) begin
					state_d = srcast_pkg::ST_FOLD;
				end else if (den == '0 || num[DW-1] || num == '0) begin
					adv = 1'b1;
				end else if (num >= den) begin
					adv  = 1'b1;
					frac = ONE;
				end else begin
					div_start = 1'b1;
					state_d   = srcast_pkg::ST_DIV;
				end
			end
			srcast_pkg::ST_DIV: begin
				if (div_stat.done) begin
					adv  = 1'b1;
					frac = FW'(div_q);
				end
			end
			srcast_pkg::ST_FOLD: begin
				if (!out_v_q || out_ch.ready) begin
					fold_go = 1'b1;
					state_d = srcast_pkg::ST_IDLE;
				end
			end
			default: state_d = srcast_pkg::ST_IDLE;
		endcase
		if (adv)
			state_d = (k_q == srcast_pkg::AXIS_SEG_N) ? srcast_pkg::ST_FOLD
				: srcast_pkg::ST_MUL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= srcast_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q      <= '0;
			k_q      <= srcast_pkg::AXIS_RAY;
			mul_v_s1 <= 1'b0;
			min_q    <= ONE;
			out_v_q  <= 1'b0;
			sep_q    <= 1'b0;
		end else begin
			mul_v_s1 <= (state_q == srcast_pkg::ST_MUL) && (m_q != 4'd8);
			if (state_q == srcast_pkg::ST_MUL && m_q != 4'd8)
				m_q <= m_q + 1'b1;
			if (in_ch.valid && in_ch.ready) begin
				m_q   <= '0;
				k_q   <= srcast_pkg::AXIS_RAY;
				sep_q <= 1'b0;
			end
			if (state_q == srcast_pkg::ST_CHECK && sep)
				sep_q <= 1'b1;
			if (adv) begin
				m_q <= '0;
				k_q <= k_q + 1'b1;
			end
			if (out_ch.ready)
				out_v_q <= 1'b0;
			if (fold_go) begin
				if (last_q) begin
					out_v_q <= 1'b1;
					min_q   <= ONE;
				end else begin
					min_q <= new_min;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		mul_tag_s1 <= m_q[2:0];
		if (in_ch.valid && in_ch.ready) begin
			p_q[0] <= in_ch.ray_from_x;
			p_q[1] <= in_ch.ray_from_y;
			p_q[2] <= in_ch.ray_to_x;
			p_q[3] <= in_ch.ray_to_y;
			p_q[4] <= in_ch.seg_a_x;
			p_q[5] <= in_ch.seg_a_y;
			p_q[6] <= in_ch.seg_b_x;
			p_q[7] <= in_ch.seg_b_y;
			last_q <= in_ch.last_segment;
			best_q <= '0;
		end
		if (mul_v_s1) begin
			if (mul_tag_s1[0])
				s_q[mul_tag_s1[2:1]] <= s_q[mul_tag_s1[2:1]] + prod_x;
			else
				s_q[mul_tag_s1[2:1]] <= prod_x;
		end
		if (adv && frac > best_q)
			best_q <= frac;
		if (fold_go && last_q)
			out_d_q <= new_min;
	end

	assign out_ch.valid     = out_v_q;
	assign out_ch.hit_ratio = out_d_q;

	// an accepted item always starts the product sweep
	a_accept_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> (state_q == srcast_pkg::ST_MUL))
		else $error("accepted item did not start multiply sweep");

	// the divider only finishes while the sequencer waits on it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == srcast_pkg::ST_DIV))
		else $error("divider done outside divide state");

	// a new result comes only from the fold of a last item
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> ($past(state_q) == srcast_pkg::ST_FOLD && $past(last_q)))
		else $error("result raised outside fold of last item");

	// running minimum never exceeds one
	a_min_range: assert property (@(posedge clk) disable iff (!arst_n)
		min_q <= ONE)
		else $error("running minimum above one");
endmodule
